>>> rtl/stac_pkg.sv
package stac_pkg;

	localparam int DEFAULT_TABLE_DEPTH = 16;
	localparam int COEF_W = 16;
	localparam int EXP_W = 8;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DUMP   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_SAT   = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_ROTATE
	} cell_op_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t op;
		logic     place;   // no match anywhere and room left: open a slot
	} cell_ctrl_t;

endpackage

>>> rtl/sorted_term_accumulator_unit.sv
// sorted term accumulator: a table of polynomial terms kept in descending
// exponent order, one term per exponent, held in a row of cells.
// input channel (in_valid / in_stall) carries opcode, coefficient, exponent:
//   insert adds into a matching term (saturating) or opens a slot in order,
//   dump streams every stored term, clear empties the table.
// output channel (out_valid / out_stall) carries term_coefficient,
//   term_exponent, status and last; last marks the final result of an item.
// insert, clear and unused opcodes: the result shows in the cycle after the
//   item is accepted; next item can be taken in that cycle if out_stall is low.
// dump of n terms: the chain rotates one cell per cycle while the output does
//   not stall, so n results come out, and the table is back in place after
//   the last one. empty dump: one result.
// while a dump runs no item is accepted.
// a stall on the output holds the result register and the rotation, and
//   the input stalls as long as the result register cannot take a result.
// reset (arst_n low) empties the table and drops any pending result; term
//   storage itself is not cleared since entries past the count are never read.
module sorted_term_accumulator_unit #(
	parameter int TABLE_DEPTH = stac_pkg::DEFAULT_TABLE_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic        [1:0]                   opcode,
	input  logic signed [stac_pkg::COEF_W-1:0]  coefficient,
	input  logic        [stac_pkg::EXP_W-1:0]   exponent,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [stac_pkg::COEF_W-1:0]  term_coefficient,
	output logic        [stac_pkg::EXP_W-1:0]   term_exponent,
	output logic        [1:0]                   status,
	output logic                                last
);
	import stac_pkg::*;

	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   tail_cnt;
	logic               out_valid_q;
	logic signed [COEF_W-1:0] res_coef_q;
	logic [EXP_W-1:0]   res_exp_q;
	status_t            res_status_q;
	logic               res_last_q;

	logic               in_accept;
	logic               out_free;
	logic               dump_step;
	logic               is_ins;
	logic               any_eq;
	logic               any_sat;
	logic               full;
	op_t                op;
	cell_ctrl_t         ctrl;

	logic               res_load;
	logic signed [COEF_W-1:0] res_coef;
	logic [EXP_W-1:0]   res_exp;
	status_t            res_status;
	logic               res_last;

	logic        [EXP_W-1:0]  cexp  [TABLE_DEPTH];
	logic signed [COEF_W-1:0] ccoef [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0]   valid_v, gt_v, eq_v, sat_v;

	// handshake
	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE) || !out_free;
	assign in_accept = in_valid && !in_stall;
	assign op        = op_t'(opcode);
	assign dump_step = (state_q == S_DUMP) && out_free;
	assign tail_cnt  = count_q - 1'b1;

	assign is_ins  = in_accept && (op == OP_INSERT) && (coefficient != '0);
	assign any_eq  = |eq_v;
	assign any_sat = |sat_v;
	assign full    = count_q == CNT_W'(TABLE_DEPTH);

	assign ctrl.op    = is_ins ? CELL_INSERT : (dump_step ? CELL_ROTATE : CELL_HOLD);
	assign ctrl.place = !any_eq && !full;

	// the cell chain: each cell sees its left neighbor for a shift-in on
	// insert, and its right neighbor (or cell 0 at the tail) on rotate
	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		logic        [EXP_W-1:0]  l_exp, r_exp;
		logic signed [COEF_W-1:0] l_coef, r_coef;
		logic                     l_gt, l_valid;

		assign valid_v[g] = CNT_W'(g) < count_q;

		if (g == 0) begin : g_head
			assign l_exp   = exponent;
			assign l_coef  = coefficient;
			assign l_gt    = 1'b1;
			assign l_valid = 1'b0;
		end else begin : g_body
			assign l_exp   = cexp[g-1];
			assign l_coef  = ccoef[g-1];
			assign l_gt    = gt_v[g-1];
			assign l_valid = valid_v[g-1];
		end

		if (g == TABLE_DEPTH - 1) begin : g_end
			assign r_exp  = cexp[0];
			assign r_coef = ccoef[0];
		end else begin : g_mid
			// wrap to the head at the current tail
			assign r_exp  = (CNT_W'(g) == tail_cnt) ? cexp[0]  : cexp[g+1];
			assign r_coef = (CNT_W'(g) == tail_cnt) ? ccoef[0] : ccoef[g+1];
		end

		stac_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.valid      (valid_v[g]),
			.new_exp    (exponent),
			.new_coef   (coefficient),
			.left_exp   (l_exp),
			.left_coef  (l_coef),
			.left_gt    (l_gt),
			.left_valid (l_valid),
			.right_exp  (r_exp),
			.right_coef (r_coef),
			.term_exp   (cexp[g]),
			.term_coef  (ccoef[g]),
			.gt         (gt_v[g]),
			.eq         (eq_v[g]),
			.sat        (sat_v[g])
		);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept && (op == OP_DUMP) && (count_q != '0)) begin
					state_d = S_DUMP;
				end
			end
			S_DUMP: begin
				if (dump_step && (k_q == tail_cnt)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// result selection
	always_comb begin
		res_load   = 1'b0;
		res_coef   = '0;
		res_exp    = '0;
		res_status = ST_OK;
		res_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (in_accept) begin
					res_load = 1'b1;
					unique case (op)
						OP_INSERT: begin
							if (coefficient == '0) begin
								res_status = ST_OK;
							end else if (any_eq) begin
								res_status = any_sat ? ST_SAT : ST_OK;
							end else if (full) begin
								res_status = ST_FULL;
							end
						end
						OP_DUMP: begin
							// a non-empty dump streams from the dump state
							res_load   = (count_q == '0);
							res_status = ST_EMPTY;
						end
						default: res_status = ST_OK;
					endcase
				end
			end
			S_DUMP: begin
				res_load = dump_step;
				res_coef = ccoef[0];
				res_exp  = cexp[0];
				res_last = k_q == tail_cnt;
			end
			default: res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (is_ins && ctrl.place) begin
				count_q <= count_q + 1'b1;
			end else if (in_accept && (op == OP_CLEAR)) begin
				count_q <= '0;
			end
			if (state_q == S_IDLE) begin
				k_q <= '0;
			end else if (dump_step) begin
				k_q <= k_q + 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result register, no reset needed
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_coef_q   <= res_coef;
			res_exp_q    <= res_exp;
			res_status_q <= res_status;
			res_last_q   <= res_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign term_coefficient = res_coef_q;
	assign term_exponent    = res_exp_q;
	assign status           = res_status_q;
	assign last             = res_last_q;

	// table never overfills
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("term count beyond table depth");

	// a clear empties the table by the next cycle
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && (op == OP_CLEAR) |=> count_q == '0)
		else $error("clear did not empty the table");

	// a dropped term is only reported with a full table
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (res_status_q == ST_FULL) |-> full)
		else $error("full status with room left");

	// no new item is taken while a dump runs
	a_dump_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !in_accept)
		else $error("item accepted during dump");

	// dump counter stays inside the stored terms
	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> (k_q < count_q))
		else $error("dump ran past the last term");

endmodule

>>> rtl/stac_cell.sv
module stac_cell (
	input  logic                                clk,
	input  stac_pkg::cell_ctrl_t                ctrl,
	input  logic                                valid,
	input  logic        [stac_pkg::EXP_W-1:0]   new_exp,
	input  logic signed [stac_pkg::COEF_W-1:0]  new_coef,
	input  logic        [stac_pkg::EXP_W-1:0]   left_exp,
	input  logic signed [stac_pkg::COEF_W-1:0]  left_coef,
	input  logic                                left_gt,
	input  logic                                left_valid,
	input  logic        [stac_pkg::EXP_W-1:0]   right_exp,
	input  logic signed [stac_pkg::COEF_W-1:0]  right_coef,
	output logic        [stac_pkg::EXP_W-1:0]   term_exp,
	output logic signed [stac_pkg::COEF_W-1:0]  term_coef,
	output logic                                gt,
	output logic                                eq,
	output logic                                sat
);
	import stac_pkg::*;

	logic        [EXP_W-1:0]  exp_q;
	logic signed [COEF_W-1:0] coef_q;
	logic signed [COEF_W:0]   sum;
	logic                     ovf;
	logic signed [COEF_W-1:0] merged;
	logic                     take_left;
	logic                     take_new;

	assign gt = valid && (exp_q > new_exp);
	assign eq = valid && (exp_q == new_exp);

	// widened add, clamp toward the sign of the true sum
	assign sum    = {coef_q[COEF_W-1], coef_q} + {new_coef[COEF_W-1], new_coef};
	assign ovf    = sum[COEF_W] != sum[COEF_W-1];
	assign merged = ovf ? {sum[COEF_W], {(COEF_W-1){~sum[COEF_W]}}} : sum[COEF_W-1:0];
	assign sat    = eq && ovf;

	assign take_left = left_valid && !left_gt;
	assign take_new  = left_gt && !gt;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_INSERT: begin
				if (eq) begin
					coef_q <= merged;
				end else if (ctrl.place && take_left) begin
					exp_q  <= left_exp;
					coef_q <= left_coef;
				end else if (ctrl.place && take_new) begin
					exp_q  <= new_exp;
					coef_q <= new_coef;
				end
			end
			CELL_ROTATE: begin
				exp_q  <= right_exp;
				coef_q <= right_coef;
			end
			default: begin
			end
		endcase
	end

	assign term_exp  = exp_q;
	assign term_coef = coef_q;

endmodule

>>> tb/sv/tb_sorted_term_accumulator_unit.sv
`timescale 1ns / 100ps

module tb_sorted_term_accumulator_unit;

	import stac_pkg::*;

	localparam int DEPTH = DEFAULT_TABLE_DEPTH;
	// opcode 3 has no package name; the block answers it like a no-op
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RANDOM_ITEMS = 440;

	// one item on the input channel, plus a flag that makes the sender
	// wait until every outstanding result is back before offering it
	typedef struct {
		logic [1:0]               op;
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         expo;
		bit                       drain_first;
	} term_req_t;

	// one result on the output channel
	typedef struct {
		logic signed [COEF_W-1:0] coef;
		logic [EXP_W-1:0]         expo;
		status_t                  st;
		logic                     last;
	} term_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid = 1'b0;
	logic                      in_stall;
	logic [1:0]                opcode = '0;
	logic signed [COEF_W-1:0]  coefficient = '0;
	logic [EXP_W-1:0]          exponent = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [COEF_W-1:0]  term_coefficient;
	logic [EXP_W-1:0]          term_exponent;
	logic [1:0]                status;
	logic                      last;

	sorted_term_accumulator_unit #(
		.TABLE_DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.coefficient(coefficient),
		.exponent(exponent),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.term_coefficient(term_coefficient),
		.term_exponent(term_exponent),
		.status(status),
		.last(last)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// private copy of the term table, updated as items are accepted
	logic [EXP_W-1:0]         tbl_exp [DEPTH];
	logic signed [COEF_W-1:0] tbl_coef [DEPTH];
	int                       tbl_count = 0;

	term_req_t pending_items[$];
	term_out_t expected_terms[$];
	term_req_t cur;
	term_out_t want;

	// sent, expected and result counters, read across processes, are only advanced with nonblocking updates
	int n_sent = 0;
	int n_expected = 0;
	int n_results = 0;
	int n_queued = 0;
	int n_errors = 0;

	// coverage tallies kept by the predictor
	int n_dumps = 0;
	int n_empty = 0;
	int n_sat = 0;
	int n_full = 0;
	int n_spare = 0;
	int max_dump = 0;

	// receiver hold-off bookkeeping
	int hold_left = 0;
	bit hold_done = 1'b0;

	task automatic report_mismatch(input string what);
		if (n_errors < 40)
			$display("mismatch at %0t ns: %s", $time, what);
		n_errors++;
	endtask

	function automatic void expect_term(input logic signed [COEF_W-1:0] c,
	                                    input logic [EXP_W-1:0] e, input status_t st,
	                                    input logic lst);
		term_out_t o;
		o.coef = c;
		o.expo = e;
		o.st   = st;
		o.last = lst;
		expected_terms.push_back(o);
	endfunction

	// apply one accepted item to the private table, queue what it should
	// produce and return how many results that is
	function automatic int predict_terms(input term_req_t r);
		int pos;
		int sum;
		int k;
		status_t st;
		pos = 0;
		st = ST_OK;
		if (r.op == OP_DUMP) begin
			n_dumps++;
			if (tbl_count == 0) begin
				n_empty++;
				expect_term('0, '0, ST_EMPTY, 1'b1);
				return 1;
			end
			for (k = 0; k < tbl_count; k++)
				expect_term(tbl_coef[k], tbl_exp[k], ST_OK, k == tbl_count - 1);
			if (tbl_count > max_dump)
				max_dump = tbl_count;
			return tbl_count;
		end
		if (r.op == OP_CLEAR) begin
			tbl_count = 0;
		end else if (r.op == OP_SPARE) begin
			n_spare++;
		end else if (r.coef != 0) begin
			// zero coefficient leaves the table alone
			while (pos < tbl_count && tbl_exp[pos] > r.expo)
				pos++;
			if (pos < tbl_count && tbl_exp[pos] == r.expo) begin
				// same exponent: add with saturation, a zero sum stays in place
				sum = tbl_coef[pos] + r.coef;
				if (sum > 32767) begin
					tbl_coef[pos] = 16'sh7fff;
					st = ST_SAT;
				end else if (sum < -32768) begin
					tbl_coef[pos] = 16'sh8000;
					st = ST_SAT;
				end else begin
					tbl_coef[pos] = sum[COEF_W-1:0];
				end
				if (st == ST_SAT)
					n_sat++;
			end else if (tbl_count >= DEPTH) begin
				// new exponent with no room left is dropped
				st = ST_FULL;
				n_full++;
			end else begin
				for (k = tbl_count; k > pos; k--) begin
					tbl_exp[k]  = tbl_exp[k-1];
					tbl_coef[k] = tbl_coef[k-1];
				end
				tbl_exp[pos]  = r.expo;
				tbl_coef[pos] = r.coef;
				tbl_count++;
			end
		end
		expect_term('0, '0, st, 1'b1);
		return 1;
	endfunction

	// ---------------------------------------------------------------
	// sender: offers items from the pending queue, predicts on acceptance
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			opcode      <= '0;
			coefficient <= '0;
			exponent    <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				n_expected <= n_expected + predict_terms(cur);
				n_sent     <= n_sent + 1;
			end
			// a stalled item holds; otherwise pick what comes next
			if (!in_valid || !in_stall) begin
				if (pending_items.size() == 0 ||
				    (pending_items[0].drain_first &&
				     ((in_valid && !in_stall) || n_results != n_expected)) ||
				    (!(n_sent >= 250 && n_sent < 330) && $urandom_range(0, 99) < 22)) begin
					in_valid <= 1'b0;
				end else begin
					cur = pending_items.pop_front();
					in_valid    <= 1'b1;
					opcode      <= cur.op;
					coefficient <= cur.coef;
					exponent    <= cur.expo;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// receiver: random stall, checks every accepted result in order
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				n_results <= n_results + 1;
				if (expected_terms.size() == 0) begin
					report_mismatch($sformatf("result with nothing pending: coef %0d exp %0d",
						term_coefficient, term_exponent));
				end else begin
					want = expected_terms.pop_front();
					if (term_coefficient !== want.coef)
						report_mismatch($sformatf("term_coefficient %0d, want %0d",
							term_coefficient, want.coef));
					if (term_exponent !== want.expo)
						report_mismatch($sformatf("term_exponent %0d, want %0d",
							term_exponent, want.expo));
					if (status !== want.st)
						report_mismatch($sformatf("status %0d, want %s",
							status, want.st.name()));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, want %0b", last, want.last));
				end
			end
			// no random stall for a stretch of results, and never during the hold-off
			out_stall <= (hold_left != 0) ||
				(!(n_results >= 400 && n_results < 520) && $urandom_range(0, 99) < 22);
		end
	end

	// long receiver hold-off once traffic is flowing, so the block backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_results >= 150) begin
			hold_left <= 80;
			hold_done <= 1'b1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------
	task automatic push_item(input logic [1:0] op, input int c, input int e,
	                         input bit drain = 1'b0);
		term_req_t r;
		r.op = op;
		r.coef = c[COEF_W-1:0];
		r.expo = e[EXP_W-1:0];
		r.drain_first = drain;
		pending_items.push_back(r);
		n_queued++;
	endtask

	// mostly small values, with zeros, extremes and raw 16-bit patterns mixed in
	function automatic int pick_coef();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 0;
		if (r < 22)
			return ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(28000, 32767);
		if (r < 38)
			return int'($signed(16'($urandom)));
		return int'($urandom_range(0, 400)) - 200;
	endfunction

	initial begin
		int k;
		int n;
		int base;
		int span;
		int pick;

		// directed: empty dump, ignored zero, both saturations, zero sum, spare opcode
		push_item(OP_DUMP, 0, 0);
		push_item(OP_INSERT, 0, 5);
		push_item(OP_INSERT, 32767, 255);
		push_item(OP_INSERT, 1, 255);
		push_item(OP_INSERT, -32768, 0);
		push_item(OP_INSERT, -1, 0);
		push_item(OP_INSERT, 5, 100);
		push_item(OP_INSERT, -5, 100);
		push_item(OP_SPARE, -1, 255);
		push_item(OP_DUMP, 123, 45);
		// fill the table, then a drop and a merge while full
		for (k = 0; k < 13; k++)
			push_item(OP_INSERT, (k % 2 ? -1 : 1) * (k * 1234 + 1), 8 + 16 * k);
		push_item(OP_INSERT, 77, 1);
		push_item(OP_INSERT, 7, 100);
		push_item(OP_DUMP, 0, 0);
		push_item(OP_CLEAR, 0, 0, 1'b1);

		// random: mostly polynomial sums (clear, two polynomials, dump), some noise
		n_queued = 0;
		while (n_queued < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 72) begin
				// now and then keep the old table so it fills up
				if ($urandom_range(0, 3) != 0)
					push_item(OP_CLEAR, pick_coef(), $urandom_range(0, 255),
						$urandom_range(0, 9) == 0);
				base = $urandom_range(0, 255);
				span = $urandom_range(0, 2) == 0 ? 256 : $urandom_range(4, 40);
				repeat (2) begin
					n = $urandom_range(1, 9);
					repeat (n)
						push_item(OP_INSERT, pick_coef(),
							(base + $urandom_range(0, span - 1)) % 256);
				end
				push_item(OP_DUMP, pick_coef(), $urandom_range(0, 255));
			end else begin
				n = $urandom_range(1, 6);
				repeat (n)
					push_item(2'($urandom_range(0, 3)), int'($signed(16'($urandom))),
						$urandom_range(0, 255));
			end
		end
		push_item(OP_DUMP, 0, 0);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// all items taken, every result back, then a short quiet tail
		do @(negedge clk); while (pending_items.size() != 0 || in_valid);
		do @(negedge clk); while (n_results != n_expected);
		repeat (40) @(posedge clk);
		if (expected_terms.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_terms.size()));

		$display("covered %0d items: %0d dumps (%0d empty, longest %0d terms), %0d results",
			n_sent, n_dumps, n_empty, max_dump, n_results);
		$display("saturations %0d, full-table drops %0d, spare opcodes %0d, mismatches %0d",
			n_sat, n_full, n_spare, n_errors);
		if (n_errors == 0)
			$display("tb_sorted_term_accumulator_unit: done, clean");
		else
			$display("tb_sorted_term_accumulator_unit: done, errors");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("timeout at %0t ns", $time);
		$display("tb_sorted_term_accumulator_unit: done, errors");
		$finish;
	end

endmodule

>>> files.f
rtl/stac_pkg.sv
rtl/stac_cell.sv
rtl/sorted_term_accumulator_unit.sv
tb/sv/tb_sorted_term_accumulator_unit.sv
